@@ hw/rtl/step_doubling_error_estimator_macros.svh @@
// Assertion helpers for the error estimator
`ifndef STEP_DOUBLING_ERROR_ESTIMATOR_MACROS_SVH
`define STEP_DOUBLING_ERROR_ESTIMATOR_MACROS_SVH

// same-cycle implication
`define SDE_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("sde assertion failed");

// next-cycle implication
`define SDE_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("sde assertion failed");

`endif

@@ hw/rtl/sde_pkg.sv @@
package sde_pkg;

    localparam logic [2:0] REG_ATOL  = 3'd0;
    localparam logic [2:0] REG_RTOL  = 3'd1;
    localparam logic [2:0] REG_ORDER = 3'd2;
    localparam logic [2:0] REG_VEL   = 3'd3;

    localparam logic [31:0] ATOL_RESET  = 32'd65;
    localparam logic [31:0] RTOL_RESET  = 32'd4295;
    localparam logic [3:0]  ORDER_RESET = 4'd2;

    localparam logic [47:0] RATIO_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] EST_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] atol;
        logic [31:0] rtol;
        logic [3:0]  order;
        logic        use_vel;
    } cfg_t;

    typedef struct packed {
        logic last;
        logic two_pairs;
    } head_ctl_t;

endpackage

@@ hw/rtl/sde_front.sv @@
module sde_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [VALUE_WIDTH-1:0] coarse_position,
    input  logic signed [VALUE_WIDTH-1:0] fine_position,
    input  logic signed [VALUE_WIDTH-1:0] coarse_speed,
    input  logic signed [VALUE_WIDTH-1:0] fine_speed,
    input  logic                          last_element,
    input  logic                          use_vel,
    input  logic                          q_pop,
    output logic                          q_empty,
    output logic signed [VALUE_WIDTH-1:0] head_cp,
    output logic signed [VALUE_WIDTH-1:0] head_fp,
    output logic signed [VALUE_WIDTH-1:0] head_cs,
    output logic signed [VALUE_WIDTH-1:0] head_fs,
    output sde_pkg::head_ctl_t            head_ctl
);

    logic signed [VALUE_WIDTH-1:0] cp_reg [2];
    logic signed [VALUE_WIDTH-1:0] fp_reg [2];
    logic signed [VALUE_WIDTH-1:0] cs_reg [2];
    logic signed [VALUE_WIDTH-1:0] fs_reg [2];
    sde_pkg::head_ctl_t            ctl_reg [2];
    logic                          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]                    count_reg, count_next;
    logic                          do_push, do_pop;

    assign full     = (count_reg == 2'd2);
    assign q_empty  = (count_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = q_pop && !q_empty;
    assign head_cp  = cp_reg[rd_ptr_reg];
    assign head_fp  = fp_reg[rd_ptr_reg];
    assign head_cs  = cs_reg[rd_ptr_reg];
    assign head_fs  = fs_reg[rd_ptr_reg];
    assign head_ctl = ctl_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            cp_reg[wr_ptr_reg]            <= coarse_position;
            fp_reg[wr_ptr_reg]            <= fine_position;
            cs_reg[wr_ptr_reg]            <= coarse_speed;
            fs_reg[wr_ptr_reg]            <= fine_speed;
            ctl_reg[wr_ptr_reg].last      <= last_element;
            ctl_reg[wr_ptr_reg].two_pairs <= use_vel;
        end
    end

endmodule

@@ hw/rtl/sde_div.sv @@
module sde_div #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 33
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg, done_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});
    assign done  = done_reg;
    assign quo   = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        end
    end

endmodule

@@ hw/rtl/sde_back.sv @@
module sde_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sde_pkg::cfg_t                 cfg,
    input  logic                          q_empty,
    input  logic signed [VALUE_WIDTH-1:0] head_cp,
    input  logic signed [VALUE_WIDTH-1:0] head_fp,
    input  logic signed [VALUE_WIDTH-1:0] head_cs,
    input  logic signed [VALUE_WIDTH-1:0] head_fs,
    input  sde_pkg::head_ctl_t            head_ctl,
    output logic                          q_pop,
    output logic                          busy,
    input  logic                          pop,
    output logic                          empty,
    output logic [31:0]                   error_estimate,
    output logic                          saturated
);

    localparam int VW    = VALUE_WIDTH;
    localparam int FULLW = VW + 17;
    localparam int NW    = (FULLW > 64) ? 64 : FULLW;
    localparam int DNW   = (NW > 48) ? NW : 48;
    localparam int SW    = ((VW > 32) ? VW : 32) + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_SCALE = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_NEXT  = 3'd4;
    localparam logic [2:0] ST_EST   = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic          pair_reg, pair_next;
    logic [VW:0]   diff_reg, diff_next;
    logic [VW-1:0] big_reg, big_next;
    logic [VW:0]   acc_reg, acc_next;
    logic [31:0]   rsh_reg, rsh_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [47:0]   max_reg, max_next;
    logic          ovf_reg, ovf_next;
    logic [31:0]   est_reg, est_next;
    logic          sat_reg, sat_next;
    logic          oval_reg, oval_next;
    logic [31:0]   res_est_reg;
    logic          res_sat_reg;

    logic signed [VW-1:0] src_c, src_f;
    logic signed [VW:0]   dsub, ce, fe;
    logic [VW:0]          mc, mf;
    logic [VW:0]          sum;
    logic [SW-1:0]        scale_w;
    logic [FULLW-1:0]     num_full;
    logic                 div_start, div_done;
    logic [DNW-1:0]       div_num, div_quo;
    logic [SW-1:0]        div_den;
    logic                 out_free;

    assign src_c    = (state_reg == ST_IDLE) ? head_cp : head_cs;
    assign src_f    = (state_reg == ST_IDLE) ? head_fp : head_fs;
    assign ce       = (VW+1)'(src_c);
    assign fe       = (VW+1)'(src_f);
    assign dsub     = fe - ce;
    assign mc       = ce[VW] ? (VW+1)'(-ce) : ce;
    assign mf       = fe[VW] ? (VW+1)'(-fe) : fe;
    assign sum      = acc_reg + (rsh_reg[0] ? {1'b0, big_reg} : '0);
    assign scale_w  = SW'(cfg.atol) + SW'(acc_reg);
    assign num_full = {diff_reg, 16'd0};
    assign out_free = !oval_reg || pop;

    assign empty          = !oval_reg;
    assign error_estimate = res_est_reg;
    assign saturated      = res_sat_reg;
    assign busy           = (state_reg != ST_IDLE);

    sde_div #(
        .NUM_W (DNW),
        .DEN_W (SW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        pair_next  = pair_reg;
        diff_next  = diff_reg;
        big_next   = big_reg;
        acc_next   = acc_reg;
        rsh_next   = rsh_reg;
        cnt_next   = cnt_reg;
        max_next   = max_reg;
        ovf_next   = ovf_reg;
        est_next   = est_reg;
        sat_next   = sat_reg;
        oval_next  = oval_reg && !pop;
        q_pop      = 1'b0;
        div_start  = 1'b0;
        div_num    = DNW'(num_full[NW-1:0]);
        div_den    = scale_w;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pair_next  = 1'b0;
                    diff_next  = dsub[VW] ? (VW+1)'(-dsub) : dsub;
                    big_next   = (mc > mf) ? mc[VW-1:0] : mf[VW-1:0];
                    acc_next   = '0;
                    rsh_next   = cfg.rtol;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                acc_next = {1'b0, sum[VW:1]};
                rsh_next = {1'b0, rsh_reg[31:1]};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (scale_w == '0)
                begin
                    ovf_next   = 1'b1;
                    max_next   = sde_pkg::RATIO_MAX;
                    state_next = ST_NEXT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (div_quo > DNW'(sde_pkg::RATIO_MAX))
                    begin
                        ovf_next = 1'b1;
                        max_next = sde_pkg::RATIO_MAX;
                    end
                    else if (div_quo[47:0] > max_reg)
                    begin
                        max_next = div_quo[47:0];
                    end
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (!pair_reg && head_ctl.two_pairs)
                begin
                    pair_next  = 1'b1;
                    diff_next  = dsub[VW] ? (VW+1)'(-dsub) : dsub;
                    big_next   = (mc > mf) ? mc[VW-1:0] : mf[VW-1:0];
                    acc_next   = '0;
                    rsh_next   = cfg.rtol;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
                else if (!head_ctl.last)
                begin
                    q_pop      = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (cfg.atol == '0 || cfg.rtol == '0 || cfg.order == '0 || ovf_reg)
                begin
                    est_next   = sde_pkg::EST_MAX;
                    sat_next   = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = DNW'(max_reg);
                    div_den    = SW'((16'd1 << cfg.order) - 16'd1);
                    state_next = ST_EST;
                end
            end
            ST_EST:
            begin
                if (div_done)
                begin
                    if (div_quo > DNW'(sde_pkg::EST_MAX))
                    begin
                        est_next = sde_pkg::EST_MAX;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        est_next = div_quo[31:0];
                        sat_next = 1'b0;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    oval_next  = 1'b1;
                    max_next   = '0;
                    ovf_next   = 1'b0;
                    q_pop      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            max_reg   <= '0;
            ovf_reg   <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            max_reg   <= max_next;
            ovf_reg   <= ovf_next;
            oval_reg  <= oval_next;
        end
    end

    // the result register takes est/sat only on emit
    always_ff @(posedge clk)
    begin
        pair_reg <= pair_next;
        diff_reg <= diff_next;
        big_reg  <= big_next;
        acc_reg  <= acc_next;
        rsh_reg  <= rsh_next;
        cnt_reg  <= cnt_next;
        est_reg  <= est_next;
        sat_reg  <= sat_next;
        if (state_reg == ST_EMIT && out_free)
        begin
            res_est_reg <= est_reg;
            res_sat_reg <= sat_reg;
        end
    end

endmodule

@@ hw/rtl/step_doubling_error_estimator.sv @@
// Channel  | Handshake                 | Payload
// input    | push / full               | coarse/fine position, coarse/fine speed, last_element
// result   | empty / pop               | error_estimate, saturated
// config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// A pair runs a shift-add tolerance product over the 32 bits of rtol, a scale step, a divide
// on a divider of width DW = max(VALUE_WIDTH+17 capped at 64, 48), and a wrap-up step; the
// first pair adds an issue step. An item holds one pair, or two with velocity, and a last
// item adds a divide by 2^p-1 on the same divider, then an emit.
// A two-entry input queue lets the front take items while the back works; reset clears it,
// the running maximum, the result slot and the state register; a result waits for a free slot.
module step_doubling_error_estimator #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [VALUE_WIDTH-1:0] coarse_position,
    input  logic signed [VALUE_WIDTH-1:0] fine_position,
    input  logic signed [VALUE_WIDTH-1:0] coarse_speed,
    input  logic signed [VALUE_WIDTH-1:0] fine_speed,
    input  logic                          last_element,
    input  logic                          pop,
    output logic                          empty,
    output logic [31:0]                   error_estimate,
    output logic                          saturated,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [31:0]                   cfg_data
);

`include "step_doubling_error_estimator_macros.svh"

    sde_pkg::cfg_t      cfg_reg;
    sde_pkg::head_ctl_t head_ctl;
    logic                          q_pop, q_empty, busy;
    logic signed [VALUE_WIDTH-1:0] head_cp, head_fp, head_cs, head_fs;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.atol    <= sde_pkg::ATOL_RESET;
            cfg_reg.rtol    <= sde_pkg::RTOL_RESET;
            cfg_reg.order   <= sde_pkg::ORDER_RESET;
            cfg_reg.use_vel <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sde_pkg::REG_ATOL:  cfg_reg.atol    <= cfg_data;
                sde_pkg::REG_RTOL:  cfg_reg.rtol    <= cfg_data;
                sde_pkg::REG_ORDER: cfg_reg.order   <= cfg_data[3:0];
                sde_pkg::REG_VEL:   cfg_reg.use_vel <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    sde_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .coarse_position (coarse_position),
        .fine_position   (fine_position),
        .coarse_speed    (coarse_speed),
        .fine_speed      (fine_speed),
        .last_element    (last_element),
        .use_vel         (cfg_reg.use_vel),
        .q_pop           (q_pop),
        .q_empty         (q_empty),
        .head_cp         (head_cp),
        .head_fp         (head_fp),
        .head_cs         (head_cs),
        .head_fs         (head_fs),
        .head_ctl        (head_ctl)
    );

    sde_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_empty        (q_empty),
        .head_cp        (head_cp),
        .head_fp        (head_fp),
        .head_cs        (head_cs),
        .head_fs        (head_fs),
        .head_ctl       (head_ctl),
        .q_pop          (q_pop),
        .busy           (busy),
        .pop            (pop),
        .empty          (empty),
        .error_estimate (error_estimate),
        .saturated      (saturated)
    );

    `SDE_ASSERT_NOW(a_sat_all_ones, clk, rst_n, !empty && saturated, error_estimate == 32'hFFFF_FFFF)
    `SDE_ASSERT_NOW(a_busy_has_item, clk, rst_n, busy, !q_empty)
    `SDE_ASSERT_NEXT(a_push_fills, clk, rst_n, push && !full, !q_empty)

endmodule
